/* rtl/lcg_jump_ahead_generator_macros.svh */
// Assertion macros used by the checker file.
`ifndef LCG_JUMP_AHEAD_GENERATOR_MACROS_SVH
`define LCG_JUMP_AHEAD_GENERATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define LJA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define LJA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lja_pkg.sv */
`default_nettype none
package lja_pkg;

	localparam int STATE_W     = 64;
	localparam int DRAWN_W     = 7;
	localparam int REG_IDX_W   = 2;
	localparam int MAX_REJECTS = 64;

	localparam logic [STATE_W-1:0] MULT_RESET = 64'd6364136223846793005;
	localparam logic [STATE_W-1:0] INC_RESET  = 64'd1442695040888963407;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_JUMP = 2'd1,
		CMD_STEP = 2'd2,
		CMD_DRAW = 2'd3
	} lja_cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MULTIPLIER = 2'd0,
		REG_INCREMENT  = 2'd1,
		REG_UNBIASED   = 2'd2
	} lja_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JBIT,
		ST_ACC_MUL,
		ST_ACC_ADD,
		ST_POW_ADD,
		ST_POW_MUL,
		ST_APPLY,
		ST_ADVANCE,
		ST_CHECK,
		ST_MAP,
		ST_REPLY
	} lja_fsm_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [STATE_W-1:0] operand;
	} lja_in_t;

	typedef struct packed {
		logic [STATE_W-1:0] state_value;
		logic [DRAWN_W-1:0] drawn_number;
	} lja_out_t;

	typedef struct packed {
		logic               go;
		logic [STATE_W-1:0] a;
		logic [STATE_W-1:0] b;
		logic [STATE_W-1:0] c;
	} lja_mac_req_t;

	typedef struct packed {
		logic               done;
		logic [STATE_W-1:0] value;
	} lja_mac_rsp_t;

	typedef struct packed {
		logic               go;
		logic [STATE_W-1:0] value;
	} lja_mod_req_t;

	typedef struct packed {
		logic               done;
		logic [DRAWN_W-1:0] drawn;
	} lja_mod_rsp_t;

endpackage
`default_nettype wire

/* rtl/lja_mac.sv */
`default_nettype none
module lja_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lja_pkg::lja_mac_req_t req,
	output lja_pkg::lja_mac_rsp_t  rsp
);

	localparam int W    = lja_pkg::STATE_W;
	localparam int HALF = W / 2;

	logic [W-1:0]    a_q, b_q, acc_q, prod_q;
	logic [1:0]      phase_q;
	logic            run_q, done_q;
	logic [HALF-1:0] mul_a, mul_b;
	logic [W-1:0]    prod;

	always_comb begin
		mul_a = (phase_q == 2'd2) ? a_q[W-1:HALF] : a_q[HALF-1:0];
		mul_b = (phase_q == 2'd1) ? b_q[W-1:HALF] : b_q[HALF-1:0];
		prod  = mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q   <= 1'b1;
				phase_q <= 2'd0;
			end else if (run_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= req.c;
		end else if (run_q) begin
			prod_q <= prod;
			case (phase_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= acc_q + prod_q;
				2'd2: acc_q <= acc_q + {prod_q[HALF-1:0], {HALF{1'b0}}};
				2'd3: acc_q <= acc_q + {prod_q[HALF-1:0], {HALF{1'b0}}};
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = acc_q;

endmodule
`default_nettype wire

/* rtl/lja_mod.sv */
`default_nettype none
module lja_mod #(
	parameter int MAP_RANGE = 80
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lja_pkg::lja_mod_req_t req,
	output lja_pkg::lja_mod_rsp_t  rsp
);

	localparam int W      = lja_pkg::STATE_W;
	localparam int DW     = lja_pkg::DRAWN_W;
	localparam int NB     = W / 8;
	localparam int FOLD_W = 19;
	localparam int PROD_W = 2 * FOLD_W + 1;
	localparam int SHIFT  = FOLD_W + $clog2(MAP_RANGE);
	localparam int SUM_W  = 9;
	localparam logic [FOLD_W:0] RECIP =
		(FOLD_W + 1)'(((64'd1 << SHIFT) + 64'(MAP_RANGE) - 64'd1) / 64'(MAP_RANGE));
	localparam logic [FOLD_W-1:0] RANGE_F = FOLD_W'(MAP_RANGE);
	localparam logic [1:0]        LAST    = 2'd2;

	// weight of byte i is 2^(8*i) mod MAP_RANGE
	function automatic logic [W-1:0] byte_weights();
		logic [W-1:0] wv;
		logic [15:0]  k;
		wv = '0;
		k  = 16'd1;
		for (int i = 0; i < NB; i++) begin
			wv[8*i +: 8] = k[7:0];
			k = (k * 16'd256) % 16'(MAP_RANGE);
		end
		return wv;
	endfunction

	localparam logic [W-1:0] WEIGHTS = byte_weights();

	logic [W-1:0]      val_q;
	logic [FOLD_W-1:0] fold, fold_q, quot, quot_q, rem;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  sum;
	logic [1:0]        step_q;
	logic              run_q, done_q;
	logic [DW-1:0]     drawn_q;

	always_comb begin
		fold = '0;
		for (int i = 0; i < NB; i++)
			fold = fold + FOLD_W'(val_q[8*i +: 8]) * FOLD_W'(WEIGHTS[8*i +: 8]);
		prod = PROD_W'(fold_q) * PROD_W'(RECIP);
		quot = FOLD_W'(prod >> SHIFT);
		rem  = fold_q - quot_q * RANGE_F;
		sum  = SUM_W'(rem) + SUM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= 2'd0;
			end else if (run_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			val_q <= req.value;
		end else if (run_q) begin
			case (step_q)
				2'd0:    fold_q  <= fold;
				2'd1:    quot_q  <= quot;
				default: drawn_q <= sum[DW-1:0];
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.drawn = drawn_q;

endmodule
`default_nettype wire

/* rtl/lcg_jump_ahead_generator.sv */
`default_nettype none
// 64-bit LCG with jump-ahead. Raise start while busy is low to issue one command;
// the result appears on result for exactly one cycle with done high, and must be
// taken then, since the block cannot be stalled. The multiplies run through one
// multiply-add unit that forms a 64-bit product from three 32x32 partial products;
// a small fold and reciprocal unit reduces a drawn raw value modulo MAP_RANGE and
// adds one. A jump walks the count bits from the lowest: each set bit folds the
// current power into the accumulated transform, each bit below the highest set bit
// also updates the power, and the accumulated transform is then applied to the
// state. A draw steps the state and, in unbiased mode, steps again for each raw
// value above LIMIT, for at most 64 rejections, before mapping the value.
module lcg_jump_ahead_generator #(
	parameter int MAP_RANGE = 80
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire lja_pkg::lja_in_t                request,
	output logic                                 done,
	output lja_pkg::lja_out_t                    result,
	input  wire logic                            cfg_we,
	input  wire logic [lja_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [lja_pkg::STATE_W-1:0]     cfg_data
);

	localparam int W   = lja_pkg::STATE_W;
	localparam int DW  = lja_pkg::DRAWN_W;
	localparam int TRY_W = $clog2(lja_pkg::MAX_REJECTS + 1);
	localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
	localparam logic [W-1:0] LIMIT = ALL_ONES - (ALL_ONES % W'(MAP_RANGE));
	localparam logic [TRY_W-1:0] TRY_MAX = TRY_W'(lja_pkg::MAX_REJECTS);

	lja_pkg::lja_fsm_t     fsm_q, fsm_d;
	lja_pkg::lja_mac_req_t mac_req;
	lja_pkg::lja_mac_rsp_t mac_rsp;
	lja_pkg::lja_mod_req_t mod_req;
	lja_pkg::lja_mod_rsp_t mod_rsp;

	logic [W-1:0]     gen_q, mul_q, inc_q;
	logic             unb_q;
	logic [W-1:0]     cnt_q, acc_mul_q, acc_add_q, pow_mul_q, pow_add_q;
	logic [TRY_W-1:0] tries_q;
	logic             draw_q, pend_q, pend_d, done_q;
	logic [DW-1:0]    drawn_q;
	lja_pkg::lja_out_t result_q;
	logic             accept, mac_fin, reject;

	assign accept  = start && (fsm_q == lja_pkg::ST_IDLE);
	assign mac_fin = pend_q && mac_rsp.done;
	assign reject  = unb_q && (gen_q > LIMIT) && (tries_q < TRY_MAX);

	always_comb begin
		fsm_d         = fsm_q;
		pend_d        = pend_q;
		mac_req.go    = 1'b0;
		mac_req.a     = mul_q;
		mac_req.b     = gen_q;
		mac_req.c     = inc_q;
		mod_req.go    = 1'b0;
		mod_req.value = gen_q;
		case (fsm_q)
			lja_pkg::ST_ACC_MUL: begin
				mac_req.a = acc_mul_q;
				mac_req.b = pow_mul_q;
				mac_req.c = '0;
			end
			lja_pkg::ST_ACC_ADD: begin
				mac_req.a = pow_mul_q;
				mac_req.b = acc_add_q;
				mac_req.c = pow_add_q;
			end
			lja_pkg::ST_POW_ADD: begin
				mac_req.a = pow_mul_q;
				mac_req.b = pow_add_q;
				mac_req.c = pow_add_q;
			end
			lja_pkg::ST_POW_MUL: begin
				mac_req.a = pow_mul_q;
				mac_req.b = pow_mul_q;
				mac_req.c = '0;
			end
			lja_pkg::ST_APPLY: begin
				mac_req.a = acc_mul_q;
				mac_req.b = gen_q;
				mac_req.c = acc_add_q;
			end
			default: begin
				mac_req.a = mul_q;
			end
		endcase
		case (fsm_q)
			lja_pkg::ST_IDLE: begin
				if (start) begin
					case (request.command)
						lja_pkg::CMD_LOAD: fsm_d = lja_pkg::ST_REPLY;
						lja_pkg::CMD_JUMP: fsm_d = lja_pkg::ST_JBIT;
						default:           fsm_d = lja_pkg::ST_ADVANCE;
					endcase
				end
			end
			lja_pkg::ST_JBIT: begin
				if (cnt_q == '0)
					fsm_d = lja_pkg::ST_APPLY;
				else if (cnt_q[0])
					fsm_d = lja_pkg::ST_ACC_MUL;
				else
					fsm_d = lja_pkg::ST_POW_ADD;
			end
			lja_pkg::ST_ACC_MUL, lja_pkg::ST_ACC_ADD, lja_pkg::ST_POW_ADD,
			lja_pkg::ST_POW_MUL, lja_pkg::ST_APPLY, lja_pkg::ST_ADVANCE: begin
				if (!pend_q) begin
					mac_req.go = 1'b1;
					pend_d     = 1'b1;
				end else if (mac_rsp.done) begin
					pend_d = 1'b0;
					case (fsm_q)
						lja_pkg::ST_ACC_MUL: fsm_d = lja_pkg::ST_ACC_ADD;
						lja_pkg::ST_ACC_ADD: fsm_d = (cnt_q[W-1:1] == '0) ?
							lja_pkg::ST_APPLY : lja_pkg::ST_POW_ADD;
						lja_pkg::ST_POW_ADD: fsm_d = lja_pkg::ST_POW_MUL;
						lja_pkg::ST_POW_MUL: fsm_d = lja_pkg::ST_JBIT;
						lja_pkg::ST_ADVANCE: fsm_d = draw_q ?
							lja_pkg::ST_CHECK : lja_pkg::ST_REPLY;
						default:             fsm_d = lja_pkg::ST_REPLY;
					endcase
				end
			end
			lja_pkg::ST_CHECK: begin
				if (reject) begin
					fsm_d = lja_pkg::ST_ADVANCE;
				end else begin
					mod_req.go = 1'b1;
					fsm_d      = lja_pkg::ST_MAP;
				end
			end
			lja_pkg::ST_MAP: begin
				if (mod_rsp.done)
					fsm_d = lja_pkg::ST_REPLY;
			end
			lja_pkg::ST_REPLY: fsm_d = lja_pkg::ST_IDLE;
			default:           fsm_d = lja_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q  <= lja_pkg::ST_IDLE;
			pend_q <= 1'b0;
			done_q <= 1'b0;
			gen_q  <= '0;
			mul_q  <= lja_pkg::MULT_RESET;
			inc_q  <= lja_pkg::INC_RESET;
			unb_q  <= 1'b1;
		end else begin
			fsm_q  <= fsm_d;
			pend_q <= pend_d;
			done_q <= (fsm_q == lja_pkg::ST_REPLY);
			if (cfg_we) begin
				case (cfg_index)
					lja_pkg::REG_MULTIPLIER: mul_q <= cfg_data;
					lja_pkg::REG_INCREMENT:  inc_q <= cfg_data;
					lja_pkg::REG_UNBIASED:   unb_q <= cfg_data[0];
					default:                 unb_q <= unb_q;
				endcase
			end
			if (accept && (request.command == lja_pkg::CMD_LOAD))
				gen_q <= request.operand;
			else if (mac_fin && ((fsm_q == lja_pkg::ST_APPLY) ||
				(fsm_q == lja_pkg::ST_ADVANCE)))
				gen_q <= mac_rsp.value;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q     <= request.operand;
			acc_mul_q <= W'(1);
			acc_add_q <= '0;
			pow_mul_q <= mul_q;
			pow_add_q <= inc_q;
			tries_q   <= '0;
			draw_q    <= (request.command == lja_pkg::CMD_DRAW);
			drawn_q   <= '0;
		end
		if (mac_fin) begin
			case (fsm_q)
				lja_pkg::ST_ACC_MUL: acc_mul_q <= mac_rsp.value;
				lja_pkg::ST_ACC_ADD: acc_add_q <= mac_rsp.value;
				lja_pkg::ST_POW_ADD: pow_add_q <= mac_rsp.value;
				lja_pkg::ST_POW_MUL: begin
					pow_mul_q <= mac_rsp.value;
					cnt_q     <= {1'b0, cnt_q[W-1:1]};
				end
				default: cnt_q <= cnt_q;
			endcase
		end
		if ((fsm_q == lja_pkg::ST_CHECK) && reject)
			tries_q <= tries_q + TRY_W'(1);
		if ((fsm_q == lja_pkg::ST_MAP) && mod_rsp.done)
			drawn_q <= mod_rsp.drawn;
		if (fsm_q == lja_pkg::ST_REPLY) begin
			result_q.state_value  <= gen_q;
			result_q.drawn_number <= drawn_q;
		end
	end

	lja_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	lja_mod #(
		.MAP_RANGE (MAP_RANGE)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign busy   = (fsm_q != lja_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

/* rtl/lja_checker.sv */
`default_nettype none
`include "lcg_jump_ahead_generator_macros.svh"
module lja_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	`LJA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted command did not raise busy")
	`LJA_ASSERT_NOW(a_fall_done, clk, arst_n, $fell(busy), done, "busy dropped without a result")
	`LJA_ASSERT_NOW(a_done_fall, clk, arst_n, done, $fell(busy), "result without a finished command")
	`LJA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held past one cycle")

endmodule

bind lcg_jump_ahead_generator lja_checker u_checker (.*);
`default_nettype wire
